### sv/prpr_pkg.sv
`default_nettype none
package prpr_pkg;

	localparam int SLOT_W  = 10;
	localparam int COUNT_W = 11;
	localparam int CHAN_W  = 12;
	localparam int FREQ_W  = 40;
	localparam int ANGLE_W = 64;
	localparam int PHS_W   = 32;

	localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_REQ   = 1'b1;

	localparam logic [2:0] ADDR_MODE    = 3'd0;
	localparam logic [2:0] ADDR_SPACING = 3'd4;

	typedef logic signed [PHS_W-1:0] phs_t;

	// atan(2^-i) in 2^-32 turn, rounded; zero past the last entry
	function automatic logic [31:0] atan_turn(input logic [5:0] i);
		logic [31:0] r;
		case (i)
			6'd0:  r = 32'd536870912;
			6'd1:  r = 32'd316933406;
			6'd2:  r = 32'd167458907;
			6'd3:  r = 32'd85004756;
			6'd4:  r = 32'd42667331;
			6'd5:  r = 32'd21354465;
			6'd6:  r = 32'd10680862;
			6'd7:  r = 32'd5340245;
			6'd8:  r = 32'd2670163;
			6'd9:  r = 32'd1335087;
			6'd10: r = 32'd667544;
			6'd11: r = 32'd333772;
			6'd12: r = 32'd166886;
			6'd13: r = 32'd83443;
			6'd14: r = 32'd41722;
			6'd15: r = 32'd20861;
			6'd16: r = 32'd10430;
			6'd17: r = 32'd5215;
			6'd18: r = 32'd2608;
			6'd19: r = 32'd1304;
			6'd20: r = 32'd652;
			6'd21: r = 32'd326;
			6'd22: r = 32'd163;
			6'd23: r = 32'd81;
			6'd24: r = 32'd41;
			6'd25: r = 32'd20;
			6'd26: r = 32'd10;
			6'd27: r = 32'd5;
			6'd28: r = 32'd3;
			6'd29: r = 32'd1;
			6'd30: r = 32'd1;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	function automatic phs_t sat32(input logic signed [63:0] v);
		phs_t r;
		if (v > 64'sd2147483647)
			r = 32'sh7fffffff;
		else if (v < -64'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage
`default_nettype wire

### sv/prpr_in_if.sv
`default_nettype none
interface prpr_in_if import prpr_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic                       cmd;
	logic [31:0]                block_start;
	logic [COUNT_W-1:0]         row_count;
	logic [SLOT_W-1:0]          row_slot;
	logic [CHAN_W-1:0]          channel;
	logic [FREQ_W-1:0]          freq_hz;
	logic signed [ANGLE_W-1:0]  angle;

	modport source(output valid, cmd, block_start, row_count, row_slot, channel, freq_hz, angle,
		input ready);
	modport sink(input valid, cmd, block_start, row_count, row_slot, channel, freq_hz, angle,
		output ready);
endinterface
`default_nettype wire

### sv/prpr_out_if.sv
`default_nettype none
interface prpr_out_if import prpr_pkg::*; ();
	logic valid;
	logic ready;
	phs_t corr_re;
	phs_t corr_im;

	modport source(output valid, corr_re, corr_im, input ready);
	modport sink(input valid, corr_re, corr_im, output ready);
endinterface
`default_nettype wire

### sv/per_row_phasor_recurrence_core.sv
// Unit-phasor source for visibility gridding, Q2.30 output.
// Channels: req (valid/ready) carries start-block (cmd 0) and phasor-request
// (cmd 1) beats; rsp (valid/ready) returns one beat per request. The APB port
// holds equidistant_mode at 0x0 and chan_spacing_hz at 0x4, written with no
// wait states, readable back.
// One beat is worked on at a time; req.ready is high only while idle.
// Requests are served by the shared 33x33 multiplier and the one-iteration
// CORDIC loop (CORDIC_STEPS iterations); the result becomes valid in the
// same cycle as req.ready returns. Direct mode runs one CORDIC pass; the
// first use of a row slot runs two (start and step phasor); a filled slot
// is wound forward by one complex multiply per channel.
// The slot is first reduced by repeated subtraction of MAX_ROWS.
// In equidistant mode a start beat that opens a new block clears one slot
// valid bit per cycle, min(row_count, MAX_ROWS) bits.
// After reset the slot valid store is swept once over all MAX_ROWS entries
// with req.ready low; configuration writes are taken throughout.
// A result waits in the rsp register while the receiver stalls; the block
// holds its finished phasor and takes no new beat until that register frees.
`default_nettype none
module per_row_phasor_recurrence_core import prpr_pkg::*; #(
	parameter int MAX_ROWS     = 1024,
	parameter int MAX_CHANNELS = 4096,
	parameter int CORDIC_STEPS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	prpr_in_if.sink          req,
	prpr_out_if.source       rsp
);

	localparam int AW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int SW   = (AW > SLOT_W) ? AW : SLOT_W;
	localparam int CNTW = ($clog2(MAX_ROWS + 1) > COUNT_W) ? $clog2(MAX_ROWS + 1) : COUNT_W;
	localparam int CW   = $clog2(MAX_CHANNELS);
	localparam int CHW  = ($clog2(MAX_CHANNELS + 1) > CHAN_W) ?
		$clog2(MAX_CHANNELS + 1) : CHAN_W;
	localparam int ITW  = $clog2(CORDIC_STEPS + 1);
	localparam int XW   = 36;

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_BLK  = 4'd2;
	localparam logic [3:0] S_MOD  = 4'd3;
	localparam logic [3:0] S_RD   = 4'd4;
	localparam logic [3:0] S_CHK  = 4'd5;
	localparam logic [3:0] S_PH   = 4'd6;
	localparam logic [3:0] S_COR  = 4'd7;
	localparam logic [3:0] S_FIN  = 4'd8;
	localparam logic [3:0] S_LOOP = 4'd9;
	localparam logic [3:0] S_CM   = 4'd10;
	localparam logic [3:0] S_WB   = 4'd11;
	localparam logic [3:0] S_OUT  = 4'd12;

	typedef struct packed {
		phs_t          ph_re;
		phs_t          ph_im;
		phs_t          st_re;
		phs_t          st_im;
		logic [CW-1:0] chan;
	} slot_t;

	// configuration
	logic        eq_mode_q;
	logic [31:0] spacing_q;

	// sequencer
	logic [3:0]      state_q;
	logic [CNTW-1:0] clr_q;
	logic [CNTW-1:0] clr_end_q;
	logic [32:0]     cur_blk_q;
	logic [2:0]      mstep_q;
	logic [ITW-1:0]  it_q;
	logic            pass_q;
	logic            first_q;
	logic            out_vld_q;

	// request payload
	logic [SLOT_W-1:0]         slot_raw_q;
	logic [CW-1:0]             chan_q;
	logic [FREQ_W-1:0]         freq_q;
	logic signed [ANGLE_W-1:0] angle_q;

	// datapath
	logic signed [65:0] mul_q;
	logic [31:0]        pacc_q;
	logic signed [63:0] re_acc_q;
	logic signed [63:0] im_acc_q;
	logic signed [XW-1:0] x_q, y_q, z_q;
	logic               neg_q;
	phs_t               ph_re_q, ph_im_q, st_re_q, st_im_q;
	logic [CW-1:0]      cur_ch_q;
	phs_t               out_re_q, out_im_q;

	// slot stores
	slot_t slot_mem [MAX_ROWS];
	logic  vld_mem  [MAX_ROWS];
	slot_t rd_q;
	logic  vld_rd_q;

	logic [SW-1:0]   slot_ext;
	logic [AW-1:0]   slot_addr;
	logic [AW-1:0]   vld_addr;
	logic            vld_we;
	logic            vld_wd;
	logic            mem_we;
	logic            cfg_we;
	logic            req_acc;
	logic [CNTW-1:0] cnt_clip;
	logic [CW-1:0]   chan_clip;
	logic [63:0]     op_a;
	logic signed [32:0] mul_a, mul_b;
	logic signed [XW-1:0] dx, dy, atan_v, x_fin, y_fin;
	logic [31:0]     ph_fold;
	logic signed [63:0] rnd_re, rnd_im;
	logic signed [63:0] neg_prod;

	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite;
	assign req_acc = req.valid && req.ready;

	always_comb begin
		case (paddr)
			ADDR_MODE:    prdata = {31'd0, eq_mode_q};
			ADDR_SPACING: prdata = spacing_q;
			default:      prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eq_mode_q <= 1'b0;
			spacing_q <= 32'd0;
		end else if (cfg_we) begin
			if (paddr == ADDR_MODE)
				eq_mode_q <= pwdata[0];
			else if (paddr == ADDR_SPACING)
				spacing_q <= pwdata;
		end
	end

	assign req.ready   = (state_q == S_IDLE);
	assign rsp.valid   = out_vld_q;
	assign rsp.corr_re = out_re_q;
	assign rsp.corr_im = out_im_q;

	// clip row count and channel at the input
	assign cnt_clip  = (CNTW'(req.row_count) > CNTW'(MAX_ROWS)) ?
		CNTW'(MAX_ROWS) : CNTW'(req.row_count);
	assign chan_clip = (CHW'(req.channel) >= CHW'(MAX_CHANNELS)) ?
		CW'(MAX_CHANNELS - 1) : CW'(req.channel);

	assign slot_ext  = SW'(slot_raw_q);
	assign slot_addr = slot_ext[AW-1:0];

	// shared multiplier operands
	assign op_a = pass_q ? {{32{spacing_q[31]}}, spacing_q} : 64'(freq_q);

	always_comb begin
		mul_a = 33'sd0;
		mul_b = 33'sd0;
		if (state_q == S_PH) begin
			case (mstep_q)
				3'd0: begin
					mul_a = {1'b0, op_a[31:0]};
					mul_b = {1'b0, angle_q[31:0]};
				end
				3'd1: begin
					mul_a = {1'b0, op_a[31:0]};
					mul_b = {1'b0, angle_q[63:32]};
				end
				3'd2: begin
					mul_a = {1'b0, op_a[63:32]};
					mul_b = {1'b0, angle_q[31:0]};
				end
				default: ;
			endcase
		end else begin
			case (mstep_q)
				3'd0: begin
					mul_a = 33'(ph_re_q);
					mul_b = 33'(st_re_q);
				end
				3'd1: begin
					mul_a = 33'(ph_im_q);
					mul_b = 33'(st_im_q);
				end
				3'd2: begin
					mul_a = 33'(ph_re_q);
					mul_b = 33'(st_im_q);
				end
				3'd3: begin
					mul_a = 33'(ph_im_q);
					mul_b = 33'(st_re_q);
				end
				default: ;
			endcase
		end
	end

	// CORDIC iteration and fold
	assign dx     = y_q >>> it_q;
	assign dy     = x_q >>> it_q;
	assign atan_v = XW'(atan_turn(6'(it_q)));
	assign ph_fold = pacc_q - 32'h8000_0000;
	assign x_fin  = neg_q ? -x_q : x_q;
	assign y_fin  = neg_q ? -y_q : y_q;

	assign neg_prod = -mul_q[63:0];
	assign rnd_re   = (re_acc_q + 64'sd268435456) >>> 29;
	assign rnd_im   = (im_acc_q + 64'sd268435456) >>> 29;

	// slot store ports
	assign mem_we   = (state_q == S_WB);
	assign vld_we   = (state_q == S_CLR) || (state_q == S_BLK) || (state_q == S_WB && first_q);
	assign vld_wd   = (state_q == S_WB);
	assign vld_addr = (state_q == S_CLR || state_q == S_BLK) ? clr_q[AW-1:0] : slot_addr;

	always_ff @(posedge clk) begin
		if (mem_we)
			slot_mem[slot_addr] <= '{ph_re: ph_re_q, ph_im: ph_im_q, st_re: st_re_q,
				st_im: st_im_q, chan: cur_ch_q};
		rd_q <= slot_mem[slot_addr];
	end

	always_ff @(posedge clk) begin
		if (vld_we)
			vld_mem[vld_addr] <= vld_wd;
		vld_rd_q <= vld_mem[vld_addr];
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_q     <= '0;
			clr_end_q <= '0;
			cur_blk_q <= '1;
			mstep_q   <= '0;
			it_q      <= '0;
			pass_q    <= 1'b0;
			first_q   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			// drop the result beat once taken, unless a new one loads now
			if (rsp.ready && state_q != S_OUT)
				out_vld_q <= 1'b0;
			case (state_q)
				S_CLR: begin
					// sweep the valid store once after reset
					clr_q <= clr_q + 1'b1;
					if (clr_q == CNTW'(MAX_ROWS - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req_acc) begin
						slot_raw_q <= req.row_slot;
						chan_q     <= chan_clip;
						freq_q     <= req.freq_hz;
						angle_q    <= req.angle;
						pass_q     <= 1'b0;
						first_q    <= 1'b0;
						if (req.cmd == CMD_REQ) begin
							state_q <= S_MOD;
						end else if (eq_mode_q && {1'b0, req.block_start} != cur_blk_q) begin
							cur_blk_q <= {1'b0, req.block_start};
							clr_q     <= '0;
							clr_end_q <= cnt_clip;
							if (cnt_clip != '0)
								state_q <= S_BLK;
						end
					end
				end
				S_BLK: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == clr_end_q - 1'b1)
						state_q <= S_IDLE;
				end
				S_MOD: begin
					// reduce the slot by repeated subtraction
					if (CNTW'(slot_raw_q) >= CNTW'(MAX_ROWS)) begin
						slot_raw_q <= slot_raw_q - SLOT_W'(MAX_ROWS);
					end else if (eq_mode_q) begin
						state_q <= S_RD;
					end else begin
						mstep_q <= '0;
						state_q <= S_PH;
					end
				end
				S_RD: state_q <= S_CHK;
				S_CHK: begin
					if (!vld_rd_q) begin
						first_q <= 1'b1;
						mstep_q <= '0;
						state_q <= S_PH;
					end else begin
						ph_re_q  <= rd_q.ph_re;
						ph_im_q  <= rd_q.ph_im;
						st_re_q  <= rd_q.st_re;
						st_im_q  <= rd_q.st_im;
						cur_ch_q <= rd_q.chan;
						state_q  <= S_LOOP;
					end
				end
				S_PH: begin
					// phase = bits 63:32 of the wrapped 64-bit product
					mstep_q <= mstep_q + 1'b1;
					case (mstep_q)
						3'd1: pacc_q <= mul_q[63:32];
						3'd2: pacc_q <= pacc_q + mul_q[31:0];
						3'd3: pacc_q <= pacc_q + mul_q[31:0];
						3'd4: begin
							// fold into a quarter turn either side of zero
							if (pacc_q[31] != pacc_q[30]) begin
								neg_q <= 1'b1;
								z_q   <= XW'($signed(ph_fold));
							end else begin
								neg_q <= 1'b0;
								z_q   <= XW'($signed(pacc_q));
							end
							x_q     <= XW'(CORDIC_GAIN_Q30);
							y_q     <= '0;
							it_q    <= '0;
							state_q <= S_COR;
						end
						default: ;
					endcase
				end
				S_COR: begin
					if (z_q >= 0) begin
						x_q <= x_q - dx;
						y_q <= y_q + dy;
						z_q <= z_q - atan_v;
					end else begin
						x_q <= x_q + dx;
						y_q <= y_q - dy;
						z_q <= z_q + atan_v;
					end
					it_q <= it_q + 1'b1;
					if (it_q == ITW'(CORDIC_STEPS - 1))
						state_q <= S_FIN;
				end
				S_FIN: begin
					if (!eq_mode_q) begin
						ph_re_q <= sat32(64'(x_fin));
						ph_im_q <= sat32(64'(y_fin));
						state_q <= S_OUT;
					end else if (!pass_q) begin
						ph_re_q <= sat32(64'(x_fin));
						ph_im_q <= sat32(64'(y_fin));
						pass_q  <= 1'b1;
						mstep_q <= '0;
						state_q <= S_PH;
					end else begin
						st_re_q  <= sat32(64'(x_fin));
						st_im_q  <= sat32(64'(y_fin));
						cur_ch_q <= chan_q;
						state_q  <= S_WB;
					end
				end
				S_LOOP: begin
					mstep_q <= '0;
					state_q <= (cur_ch_q < chan_q) ? S_CM : S_WB;
				end
				S_CM: begin
					// one complex multiply by the step phasor
					mstep_q <= mstep_q + 1'b1;
					case (mstep_q)
						3'd1: re_acc_q <= $signed(mul_q[63:0]) >>> 1;
						3'd2: re_acc_q <= re_acc_q + (neg_prod >>> 1);
						3'd3: im_acc_q <= $signed(mul_q[63:0]) >>> 1;
						3'd4: im_acc_q <= im_acc_q + ($signed(mul_q[63:0]) >>> 1);
						3'd5: begin
							ph_re_q  <= sat32(rnd_re);
							ph_im_q  <= sat32(rnd_im);
							cur_ch_q <= cur_ch_q + 1'b1;
							state_q  <= S_LOOP;
						end
						default: ;
					endcase
				end
				S_WB: state_q <= S_OUT;
				S_OUT: begin
					// hold until the result register frees
					if (!out_vld_q || rsp.ready) begin
						out_vld_q <= 1'b1;
						out_re_q  <= ph_re_q;
						out_im_q  <= ph_im_q;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_wind_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CM) |-> (cur_ch_q < chan_q))
		else $error("winding past the requested channel");

	a_slot_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD) |-> (CNTW'(slot_raw_q) < CNTW'(MAX_ROWS)))
		else $error("slot used before reduction");

	a_cordic_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COR) |-> (it_q < ITW'(CORDIC_STEPS)))
		else $error("CORDIC iteration count overrun");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !rsp.ready) |=> (out_vld_q && $stable(out_re_q)))
		else $error("pending result lost");

endmodule
`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps
`default_nettype none
module tb import prpr_pkg::*; ();

	localparam int ROWS      = 1024;
	localparam int TOP_CHAN  = 4095;
	// settle time after the last result: covers a full slot clear plus slack
	localparam int QUIET_CYC = 1200;

	// one request beat as the sender sees it
	typedef struct {
		logic                      cmd;
		logic [31:0]               start;
		logic [COUNT_W-1:0]        count;
		logic [SLOT_W-1:0]         slot;
		logic [CHAN_W-1:0]         chan;
		logic [FREQ_W-1:0]         freq;
		logic signed [ANGLE_W-1:0] angle;
	} beat_t;

	typedef struct {
		phs_t re;
		phs_t im;
	} phasor_t;

	// rows of the directed table: a beat, or a register write between beats
	typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;
	typedef struct {
		row_kind_t   kind;
		beat_t       b;
		logic [2:0]  addr;
		logic [31:0] data;
	} row_t;

	// arctangent steps in 2^-32 turn
	localparam longint ATAN_STEP [32] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10680862, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
		5, 3, 1, 1, 0
	};

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	prpr_in_if  req();
	prpr_out_if rsp();

	per_row_phasor_recurrence_core dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req(req), .rsp(rsp)
	);

	// shadow of the block's registers and slot table
	bit          mode_recur;
	logic [31:0] spacing;
	phs_t        slot_re [ROWS];
	phs_t        slot_im [ROWS];
	phs_t        slot_step_re [ROWS];
	phs_t        slot_step_im [ROWS];
	int          slot_chan [ROWS];
	bit          slot_live [ROWS];
	logic [32:0] cur_block;

	phasor_t pending_phasors[$];
	row_t    directed[$];
	int      req_idle, rsp_idle;
	int      mismatches, n_req, n_start, n_reg, n_results;
	int      blk_rows;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic phs_t clip32(input longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	// top 32 bits of the wrapped 64-bit product, in turns
	function automatic logic [31:0] turns_of(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] p;
		p = a * b;
		return p[63:32];
	endfunction

	function automatic void rotate(input logic [31:0] ph, output phs_t re, output phs_t im);
		longint x, y, z, dx, dy;
		bit flip;
		x = CORDIC_GAIN_Q30;
		y = 0;
		flip = 0;
		// fold into [-1/4, 1/4) turn, negate the result afterwards
		if (((ph + 32'h40000000) & 32'h80000000) != 0) begin
			ph = ph - 32'h80000000;
			flip = 1;
		end
		z = $signed(ph);
		for (int i = 0; i < 32; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ATAN_STEP[i];
			end else begin
				x += dx; y -= dy; z += ATAN_STEP[i];
			end
		end
		if (flip) begin
			x = -x; y = -y;
		end
		re = clip32(x);
		im = clip32(y);
	endfunction

	function automatic phs_t q30_sum(input longint p1, input longint p2);
		longint s;
		s = (p1 >>> 1) + (p2 >>> 1);
		return clip32((s + 64'sd268435456) >>> 29);
	endfunction

	// advance the shadow for one accepted beat; 1 when a phasor comes back
	function automatic bit phasor_for(input beat_t b, output phs_t re, output phs_t im);
		logic [63:0] sp;
		longint ar, ai, br, bi;
		int s, c;
		re = '0;
		im = '0;
		if (b.cmd == CMD_START) begin
			if (mode_recur && {1'b0, b.start} != cur_block) begin
				c = (b.count > ROWS) ? ROWS : b.count;
				for (int i = 0; i < c; i++)
					slot_live[i] = 0;
				cur_block = {1'b0, b.start};
			end
			return 0;
		end
		s = b.slot;
		c = b.chan;
		if (!mode_recur) begin
			rotate(turns_of({24'b0, b.freq}, b.angle), re, im);
			return 1;
		end
		if (!slot_live[s]) begin
			sp = {{32{spacing[31]}}, spacing};
			rotate(turns_of({24'b0, b.freq}, b.angle), slot_re[s], slot_im[s]);
			rotate(turns_of(sp, b.angle), slot_step_re[s], slot_step_im[s]);
			slot_chan[s] = c;
			slot_live[s] = 1;
		end else begin
			// wind forward one channel at a time; lower channels keep the stored one
			while (slot_chan[s] < c) begin
				ar = slot_re[s]; ai = slot_im[s];
				br = slot_step_re[s]; bi = slot_step_im[s];
				slot_re[s] = q30_sum(ar * br, -(ai * bi));
				slot_im[s] = q30_sum(ar * bi, ai * br);
				slot_chan[s]++;
			end
		end
		re = slot_re[s];
		im = slot_im[s];
		return 1;
	endfunction

	// send one beat, with random gaps ahead of it; valid stays high on return
	task automatic send_beat(input beat_t b);
		phasor_t e;
		if ($urandom_range(99) < req_idle) begin
			req.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < req_idle);
		end
		req.valid       <= 1'b1;
		req.cmd         <= b.cmd;
		req.block_start <= b.start;
		req.row_count   <= b.count;
		req.row_slot    <= b.slot;
		req.channel     <= b.chan;
		req.freq_hz     <= b.freq;
		req.angle       <= b.angle;
		do @(posedge clk); while (!req.ready);
		if (b.cmd == CMD_REQ)
			n_req++;
		else
			n_start++;
		if (phasor_for(b, e.re, e.im))
			pending_phasors.push_back(e);
	endtask

	// drop valid and hold until every phasor is back and any clear has ended
	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending_phasors.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYC) @(posedge clk);
	endtask

	// two-phase register write; call only once drained
	task automatic reg_write(input logic [2:0] a, input logic [31:0] d);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= a;
		pwdata  <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		if (a == ADDR_MODE)
			mode_recur = d[0];
		else
			spacing = d;
		n_reg++;
	endtask

	function automatic beat_t start_beat(input logic [31:0] st, input int cnt);
		beat_t b;
		b = '{cmd: CMD_START, start: st, count: COUNT_W'(cnt), slot: SLOT_W'($urandom),
			chan: CHAN_W'($urandom), freq: FREQ_W'({$urandom, $urandom}),
			angle: {$urandom, $urandom}};
		return b;
	endfunction

	function automatic beat_t phasor_beat(input int sl, input int ch,
			input logic [39:0] f, input logic [63:0] ang);
		beat_t b;
		b = '{cmd: CMD_REQ, start: $urandom, count: COUNT_W'($urandom),
			slot: SLOT_W'(sl), chan: CHAN_W'(ch), freq: f, angle: ang};
		return b;
	endfunction

	task automatic add_beat(input beat_t b);
		row_t r;
		r.kind = ROW_BEAT;
		r.b = b;
		directed.push_back(r);
	endtask

	task automatic add_reg(input logic [2:0] a, input logic [31:0] d);
		row_t r;
		r.kind = ROW_REG;
		r.addr = a;
		r.data = d;
		directed.push_back(r);
	endtask

	// random stimulus: mostly a new block followed by requests on its rows
	task automatic run_random(input int n);
		beat_t b;
		int done, sl, ch, r;
		logic [39:0] f;
		logic [63:0] ang;
		done = 0;
		while (done < n) begin
			if (done % 40 == 39) begin
				drain();
				reg_write(ADDR_MODE, ($urandom_range(99) < 75) ? 32'd1 : 32'd0);
				r = $urandom_range(9);
				reg_write(ADDR_SPACING, (r == 0) ? 32'h7fffffff : (r == 1) ? 32'h80000000 :
					(r < 5) ? $urandom : $urandom_range(0, 2000000) - 1000000);
			end
			r = $urandom_range(99);
			if (r < 12) begin
				r = $urandom_range(99);
				blk_rows = (r < 85) ? $urandom_range(1, 32) :
					(r < 95) ? $urandom_range(0, ROWS) : $urandom_range(ROWS + 1, 2047);
				b = start_beat(($urandom_range(9) == 0) ? cur_block[31:0] : $urandom, blk_rows);
				if (blk_rows == 0)
					blk_rows = 1;
				else if (blk_rows > ROWS)
					blk_rows = ROWS;
			end else begin
				sl = ($urandom_range(99) < 85) ? $urandom_range(0, blk_rows - 1) : $urandom_range(0, ROWS - 1);
				r = $urandom_range(199);
				if (mode_recur && slot_live[sl]) begin
					if (r == 0)
						ch = TOP_CHAN;
					else if (r < 130)
						ch = slot_chan[sl] + $urandom_range(0, 4);
					else if (r < 170)
						ch = $urandom_range(0, slot_chan[sl]);
					else
						ch = slot_chan[sl] + $urandom_range(0, 300);
					if (ch > TOP_CHAN)
						ch = TOP_CHAN;
				end else
					ch = $urandom_range(0, TOP_CHAN);
				r = $urandom_range(19);
				f = (r == 0) ? '0 : (r == 1) ? '1 : FREQ_W'({$urandom, $urandom});
				ang = (r == 2) ? 64'h8000000000000000 : (r == 3) ? 64'h7fffffffffffffff :
					{$urandom, $urandom};
				b = phasor_beat(sl, ch, f, ang);
			end
			// starts ignored in direct mode do not count
			if (b.cmd == CMD_REQ || mode_recur)
				done++;
			send_beat(b);
		end
	endtask

	// result checker and random receiver stalls
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			n_results++;
			if (pending_phasors.size() == 0) begin
				mismatches++;
				$display("%0t: phasor beat with none expected: re %0d im %0d",
					$time, rsp.corr_re, rsp.corr_im);
			end else begin
				if (rsp.corr_re !== pending_phasors[0].re) begin
					mismatches++;
					$display("%0t: corr_re expected %0d actual %0d",
						$time, pending_phasors[0].re, rsp.corr_re);
				end
				if (rsp.corr_im !== pending_phasors[0].im) begin
					mismatches++;
					$display("%0t: corr_im expected %0d actual %0d",
						$time, pending_phasors[0].im, rsp.corr_im);
				end
				void'(pending_phasors.pop_front());
			end
		end
		rsp.ready <= ($urandom_range(99) >= rsp_idle);
	end

	initial begin
		#100ms;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		req.valid = 1'b0; req.cmd = CMD_REQ; req.block_start = '0; req.row_count = '0;
		req.row_slot = '0; req.channel = '0; req.freq_hz = '0; req.angle = '0;
		rsp.ready = 1'b0;
		mode_recur = 0; spacing = '0; cur_block = '1; blk_rows = 1;
		for (int i = 0; i < ROWS; i++)
			slot_live[i] = 0;
		mismatches = 0; n_req = 0; n_start = 0; n_reg = 0; n_results = 0;
		req_idle = 28;
		rsp_idle = 77;

		// direct mode: zero phase, extremes, quarter and half turns
		add_beat(phasor_beat(0, 0, '0, '0));
		add_beat(phasor_beat(1023, TOP_CHAN, '1, 64'h7fffffffffffffff));
		add_beat(phasor_beat(0, 0, '1, 64'h8000000000000000));
		add_beat(phasor_beat(3, 7, 40'd1, 64'h4000000000000000));
		add_beat(phasor_beat(3, 7, 40'd1, 64'h8000000000000000));
		// a start while in direct mode is dropped
		add_beat(start_beat(32'd5, 10));
		add_reg(ADDR_MODE, 32'd1);
		add_reg(ADDR_SPACING, 32'd1000);
		add_beat(start_beat(32'd0, 8));
		add_beat(phasor_beat(0, 3, 40'd1400000000, 64'h0000012345678abc));
		add_beat(phasor_beat(0, 6, 40'd1400000000, 64'h0000012345678abc));
		// lower, then equal channel: stored phasor unchanged
		add_beat(phasor_beat(0, 2, 40'd1400000000, 64'h0000012345678abc));
		add_beat(phasor_beat(0, 6, 40'd1400000000, 64'h0000012345678abc));
		// same block start keeps the slots
		add_beat(start_beat(32'd0, 8));
		add_beat(phasor_beat(0, 7, 40'd1400000000, 64'h0000012345678abc));
		add_beat(phasor_beat(1023, TOP_CHAN, '1, 64'h8000000000000000));
		add_beat(phasor_beat(1023, TOP_CHAN, '1, 64'h8000000000000000));
		// row count past the table size clears all of it
		add_beat(start_beat(32'hffffffff, 2047));
		add_beat(phasor_beat(1023, 0, 40'd999, 64'hfedcba9876543210));
		add_reg(ADDR_SPACING, 32'h80000000);
		add_beat(start_beat(32'd1, 0));
		add_beat(phasor_beat(5, 0, 40'd2000000, 64'h00000000fffff000));
		add_beat(phasor_beat(5, 10, 40'd2000000, 64'h00000000fffff000));
		add_reg(ADDR_SPACING, 32'h7fffffff);
		add_beat(start_beat(32'd2, 1024));
		add_beat(phasor_beat(5, 20, 40'd2000000, 64'h00000000fffff000));
		add_beat(phasor_beat(5, 30, 40'd2000000, 64'h00000000fffff000));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table
		foreach (directed[i]) begin
			if (directed[i].kind == ROW_REG) begin
				drain();
				reg_write(directed[i].addr, directed[i].data);
			end else
				send_beat(directed[i].b);
		end

		run_random(185);
		drain();
		req_idle = 77;
		rsp_idle = 28;
		run_random(185);
		drain();
		req_idle = 0;
		rsp_idle = 0;
		run_random(185);
		drain();

		$display("Covered %0d phasor requests, %0d block starts and %0d register writes;",
			n_req, n_start, n_reg);
		$display("%0d phasors compared in direct and recurrence modes.", n_results);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
`default_nettype wire
